@@ hw/rtl/sob_pkg.sv @@
// Shared types, sizes and helper functions of the slot ownership bitmap.
package sob_pkg;

    // Sizes of the bitmap store
    localparam int NUM_SLOTS        = 16384;
    localparam int NUM_SERVERS      = 16;
    localparam int WORD_SHIFT       = 6;
    localparam int WORD_BITS        = 1 << WORD_SHIFT;
    localparam int MAX_RELEASE      = 64;
    localparam int WORDS_PER_SERVER = (NUM_SLOTS + WORD_BITS - 1) / WORD_BITS;
    localparam int TOTAL_WORDS      = NUM_SERVERS * WORDS_PER_SERVER;
    localparam int WORD_AW          = (WORDS_PER_SERVER > 1) ? $clog2(WORDS_PER_SERVER) : 1;
    localparam int ADDR_W           = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;

    // Field widths of the items
    localparam int SERVER_W = 4;
    localparam int START_W  = 14;
    localparam int END_W    = 15;
    localparam int COUNT_W  = 7;
    localparam int SLOT_W   = 14;

    // Request kinds
    typedef enum logic {
        KIND_SET     = 1'b0,
        KIND_RELEASE = 1'b1
    } t_kind;

    // Engine states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SET_RD,
        ST_SET_WR,
        ST_REL_RD,
        ST_REL_BITS,
        ST_REL_FIN
    } t_state;

    typedef struct packed {
        t_kind                kind;
        logic [SERVER_W-1:0]  server_id;
        logic [START_W-1:0]   range_start;
        logic [END_W-1:0]     range_end;
        logic [COUNT_W-1:0]   release_count;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] slot_index;
        logic              found;
        logic              last;
    } t_result;

    typedef struct packed {
        logic                 we;
        logic [ADDR_W-1:0]    waddr;
        logic [WORD_BITS-1:0] wdata;
        logic                 re;
        logic [ADDR_W-1:0]    raddr;
    } t_ram_req;

    // Encode a one-hot word into its bit position
    function automatic logic [WORD_SHIFT-1:0] onehot_index(input logic [WORD_BITS-1:0] v);
        logic [WORD_SHIFT-1:0] idx;
        idx = '0;
        for (int k = 0; k < WORD_SHIFT; k++) begin
            for (int i = 0; i < WORD_BITS; i++) begin
                if (((i >> k) & 1) == 1) begin
                    idx[k] = idx[k] | v[i];
                end
            end
        end
        return idx;
    endfunction

endpackage

@@ hw/rtl/sob_ram.sv @@
// Single-port-write, single-port-read synchronous RAM with registered read data.
module sob_ram #(
    parameter int DATA_W = 64,
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Read port, data held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ hw/rtl/sob_out.sv @@
// Output register of the result stream.
module sob_out
    import sob_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push_valid,
    input  t_result i_push,
    input  logic    i_tready,
    output logic    o_tvalid,
    output t_result o_result,
    output logic    o_free
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || i_tready;

    // Hold valid until taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_push_valid;
        end
    end

    // Load payload when the register frees up
    always_ff @(posedge i_clk) begin
        if (o_free && i_push_valid) begin
            r_result <= i_push;
        end
    end

    assign o_tvalid = r_valid;
    assign o_result = r_result;

endmodule

@@ hw/rtl/sob_engine.sv @@
// Sequencer that clears, sets and scans the bitmap words through read-modify-write.
module sob_engine
    import sob_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  t_req     i_req,
    output logic     o_req_ready,
    input  logic     i_out_free,
    output logic     o_push_valid,
    output t_result  o_push,
    output t_ram_req o_ram,
    input  logic [WORD_BITS-1:0] i_rd_data
);

    localparam logic [WORD_BITS-1:0] ONES = '1;

    t_state r_state, n_state;
    logic [ADDR_W-1:0]     r_clr, n_clr;
    logic [ADDR_W-1:0]     r_base, n_base;
    logic [WORD_AW-1:0]    r_word, n_word;
    logic [WORD_AW-1:0]    r_wfirst, n_wfirst;
    logic [WORD_AW-1:0]    r_wlast, n_wlast;
    logic [WORD_SHIFT-1:0] r_start_bit, n_start_bit;
    logic [WORD_SHIFT-1:0] r_end_bit, n_end_bit;
    logic [COUNT_W-1:0]    r_count, n_count;
    logic [COUNT_W-1:0]    r_got, n_got;
    logic [WORD_BITS-1:0]  r_val, n_val;
    logic                  r_first, n_first;
    logic                  r_pend_valid, n_pend_valid;
    logic [SLOT_W-1:0]     r_pend_slot, n_pend_slot;

    // Request decode
    logic                  accept;
    logic                  server_ok;
    logic [31:0]           end_sat;
    logic [31:0]           end_m1;
    logic                  range_ok;
    logic [COUNT_W-1:0]    count_clamp;
    logic [ADDR_W-1:0]     req_base;

    assign accept      = (r_state == ST_IDLE) && i_req_valid;
    assign server_ok   = 32'(i_req.server_id) < NUM_SERVERS;
    assign end_sat     = (32'(i_req.range_end) > NUM_SLOTS) ? NUM_SLOTS : 32'(i_req.range_end);
    assign end_m1      = end_sat - 32'd1;
    assign range_ok    = server_ok && (32'(i_req.range_start) < end_sat);
    assign count_clamp = (i_req.release_count > COUNT_W'(MAX_RELEASE)) ?
                         COUNT_W'(MAX_RELEASE) : i_req.release_count;
    assign req_base    = ADDR_W'(32'(i_req.server_id) * WORDS_PER_SERVER);

    // Word address and set mask
    logic [ADDR_W-1:0]     word_addr;
    logic [WORD_SHIFT-1:0] lo_bit, hi_bit;
    logic [WORD_BITS-1:0]  set_mask;

    assign word_addr = r_base + ADDR_W'(r_word);
    assign lo_bit    = (r_word == r_wfirst) ? r_start_bit : '0;
    assign hi_bit    = (r_word == r_wlast) ? r_end_bit : '1;
    assign set_mask  = (ONES << lo_bit) & (ONES >> (~hi_bit));

    // Lowest set bit of the current word
    logic [WORD_BITS-1:0]  cur;
    logic [WORD_BITS-1:0]  lsb;
    logic [WORD_SHIFT-1:0] bit_idx;
    logic                  has_bit;
    logic                  can_step;
    logic                  last_word;
    logic [31:0]           slot_ext;

    assign cur       = r_first ? i_rd_data : r_val;
    assign lsb       = cur & (~cur + {{(WORD_BITS-1){1'b0}}, 1'b1});
    assign bit_idx   = onehot_index(lsb);
    assign has_bit   = (cur != '0) && (r_got < r_count);
    assign can_step  = has_bit && (!r_pend_valid || i_out_free);
    assign last_word = (r_word == WORD_AW'(WORDS_PER_SERVER - 1));
    assign slot_ext  = (32'(r_word) << WORD_SHIFT) | 32'(bit_idx);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (r_clr == ADDR_W'(TOTAL_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    if (i_req.kind == KIND_SET) begin
                        n_state = range_ok ? ST_SET_RD : ST_IDLE;
                    end else begin
                        n_state = (server_ok && (count_clamp != '0)) ? ST_REL_RD : ST_REL_FIN;
                    end
                end
            end
            ST_SET_RD: n_state = ST_SET_WR;
            ST_SET_WR: begin
                n_state = (r_word == r_wlast) ? ST_IDLE : ST_SET_RD;
            end
            ST_REL_RD: n_state = ST_REL_BITS;
            ST_REL_BITS: begin
                if (!has_bit) begin
                    n_state = ((r_got == r_count) || last_word) ? ST_REL_FIN : ST_REL_RD;
                end
            end
            ST_REL_FIN: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs and datapath updates
    always_comb begin
        o_req_ready  = (r_state == ST_IDLE);
        o_push_valid = 1'b0;
        o_push       = '0;
        o_ram        = '0;
        n_clr        = r_clr;
        n_base       = r_base;
        n_word       = r_word;
        n_wfirst     = r_wfirst;
        n_wlast      = r_wlast;
        n_start_bit  = r_start_bit;
        n_end_bit    = r_end_bit;
        n_count      = r_count;
        n_got        = r_got;
        n_val        = r_val;
        n_first      = r_first;
        n_pend_valid = r_pend_valid;
        n_pend_slot  = r_pend_slot;
        unique case (r_state)
            ST_CLEAR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = r_clr;
                o_ram.wdata = '0;
                n_clr       = r_clr + ADDR_W'(1);
            end
            ST_IDLE: begin
                if (accept) begin
                    n_base       = req_base;
                    n_wfirst     = WORD_AW'(32'(i_req.range_start) >> WORD_SHIFT);
                    n_wlast      = WORD_AW'(end_m1 >> WORD_SHIFT);
                    n_start_bit  = i_req.range_start[WORD_SHIFT-1:0];
                    n_end_bit    = end_m1[WORD_SHIFT-1:0];
                    n_count      = count_clamp;
                    n_got        = '0;
                    n_pend_valid = 1'b0;
                    n_word       = (i_req.kind == KIND_SET) ?
                                   WORD_AW'(32'(i_req.range_start) >> WORD_SHIFT) : '0;
                end
            end
            ST_SET_RD: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = word_addr;
            end
            ST_SET_WR: begin
                o_ram.we    = 1'b1;
                o_ram.waddr = word_addr;
                o_ram.wdata = i_rd_data | set_mask;
                n_word      = r_word + WORD_AW'(1);
            end
            ST_REL_RD: begin
                o_ram.re    = 1'b1;
                o_ram.raddr = word_addr;
                n_first     = 1'b1;
            end
            ST_REL_BITS: begin
                n_first = 1'b0;
                n_val   = cur;
                if (can_step) begin
                    // Pass the held slot on and keep the new one back
                    o_push_valid      = r_pend_valid;
                    o_push.slot_index = r_pend_slot;
                    o_push.found      = 1'b1;
                    o_push.last       = 1'b0;
                    n_val             = cur & ~lsb;
                    n_pend_valid      = 1'b1;
                    n_pend_slot       = slot_ext[SLOT_W-1:0];
                    n_got             = r_got + COUNT_W'(1);
                end else if (!has_bit) begin
                    // Write back the scanned word
                    o_ram.we    = 1'b1;
                    o_ram.waddr = word_addr;
                    o_ram.wdata = cur;
                    n_word      = r_word + WORD_AW'(1);
                end
            end
            ST_REL_FIN: begin
                if (i_out_free) begin
                    o_push_valid      = 1'b1;
                    o_push.slot_index = r_pend_valid ? r_pend_slot : '0;
                    o_push.found      = r_pend_valid;
                    o_push.last       = 1'b1;
                    n_pend_valid      = 1'b0;
                end
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr        <= '0;
            r_first      <= 1'b0;
            r_pend_valid <= 1'b0;
            r_got        <= '0;
            r_count      <= '0;
        end else begin
            r_state      <= n_state;
            r_clr        <= n_clr;
            r_first      <= n_first;
            r_pend_valid <= n_pend_valid;
            r_got        <= n_got;
            r_count      <= n_count;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_base      <= n_base;
        r_word      <= n_word;
        r_wfirst    <= n_wfirst;
        r_wlast     <= n_wlast;
        r_start_bit <= n_start_bit;
        r_end_bit   <= n_end_bit;
        r_val       <= n_val;
        r_pend_slot <= n_pend_slot;
    end

endmodule

@@ hw/rtl/slot_ownership_bitmap.sv @@
// Top level of the per-server slot ownership bitmap with range set and lowest-slot release.
//
//  Channel   Dir  Signals                              Moves
//  s         in   i_s_tvalid o_s_tready tdata tuser     one request item
//  m         out  o_m_tvalid i_m_tready tdata tuser tlast one released-slot item
//
//  After reset a clearing pass zeroes all TOTAL_WORDS (4096) bitmap words, one a cycle;
//  no request item is taken until it ends.
//  A range set reads, then writes back, each covered bitmap word. A release reads each
//  scanned word, frees its slots one at a time, writes it back, and ends in a final
//  state; an empty server scans all 256 words. The single RAM port pair sets this
//  order; a full output register stalls a release only when an item must go out.
module slot_ownership_bitmap
    import sob_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // server_id[3:0], range_start[17:4], range_end[32:18], release_count[39:33]
    input  logic [39:0] i_s_tdata,
    // kind[0]
    input  logic        i_s_tuser,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // slot_index[13:0], zero[15:14]
    output logic [15:0] o_m_tdata,
    // found[0]
    output logic        o_m_tuser,
    output logic        o_m_tlast
);

    t_req                 req;
    t_ram_req             ram_req;
    logic [WORD_BITS-1:0] rd_data;
    logic                 out_free;
    logic                 push_valid;
    t_result              push;
    t_result              result;

    // Unpack the request item
    assign req.kind          = t_kind'(i_s_tuser);
    assign req.server_id     = i_s_tdata[3:0];
    assign req.range_start   = i_s_tdata[17:4];
    assign req.range_end     = i_s_tdata[32:18];
    assign req.release_count = i_s_tdata[39:33];

    sob_ram #(
        .DATA_W (WORD_BITS),
        .DEPTH  (TOTAL_WORDS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (rd_data)
    );

    sob_engine u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_s_tvalid),
        .i_req        (req),
        .o_req_ready  (o_s_tready),
        .i_out_free   (out_free),
        .o_push_valid (push_valid),
        .o_push       (push),
        .o_ram        (ram_req),
        .i_rd_data    (rd_data)
    );

    sob_out u_out (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .i_push       (push),
        .i_tready     (i_m_tready),
        .o_tvalid     (o_m_tvalid),
        .o_result     (result),
        .o_free       (out_free)
    );

    // Pack the result item
    assign o_m_tdata = {2'b00, result.slot_index};
    assign o_m_tuser = result.found;
    assign o_m_tlast = result.last;

endmodule

@@ tb/tb.sv @@
// Testbench for slot_ownership_bitmap: directed table and random requests vs a predictor.
module tb;
    import sob_pkg::*;

    localparam int RANDOM_ITEMS = 420;
    localparam int CALM_ITEMS   = 40;
    localparam int SETTLE       = 700;
    localparam int CYCLE_LIMIT  = 2000000;

    // One row of the directed table; want is used only where typed is set
    typedef struct {
        t_req    req;
        bit      typed;
        t_result want;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tready = 1'b0;
    logic        o_s_tready;
    logic        o_m_tvalid;
    logic [15:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;

    // Predictor state: owned slots of every server, one word per 64 slots
    logic [WORD_BITS-1:0] owned_words [TOTAL_WORDS];
    t_result              step_results [$];
    t_result              freed_q [$];
    t_stim_row            dir_rows [$];
    int unsigned          mismatch_count = 0;
    bit                   idling = 1'b1;

    slot_ownership_bitmap dut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Mark a range or release the lowest owned slots; results land in step_results
    function automatic void predict_request(input t_req r);
        int unsigned base;
        int unsigned stop;
        int unsigned want_cnt;
        int unsigned got;
        t_result     pend;
        step_results.delete();
        base = r.server_id * WORDS_PER_SERVER;
        got  = 0;
        pend = '0;
        if (r.kind == KIND_SET) begin
            if (r.server_id < NUM_SERVERS) begin
                stop = (r.range_end > NUM_SLOTS) ? NUM_SLOTS : r.range_end;
                for (int unsigned s = r.range_start; s < stop; s++) begin
                    owned_words[base + s / WORD_BITS][s % WORD_BITS] = 1'b1;
                end
            end
        end else begin
            want_cnt = (r.release_count > MAX_RELEASE) ? MAX_RELEASE : r.release_count;
            if (r.server_id < NUM_SERVERS) begin
                for (int w = 0; w < WORDS_PER_SERVER && got < want_cnt; w++) begin
                    for (int b = 0; b < WORD_BITS && got < want_cnt; b++) begin
                        if (owned_words[base + w][b]) begin
                            owned_words[base + w][b] = 1'b0;
                            if (got != 0) step_results.push_back(pend);
                            pend.slot_index = SLOT_W'(w * WORD_BITS + b);
                            pend.found      = 1'b1;
                            pend.last       = 1'b0;
                            got++;
                        end
                    end
                end
            end
            // Close the run, or report nothing found
            if (got == 0) begin
                pend.slot_index = '0;
                pend.found      = 1'b0;
            end
            pend.last = 1'b1;
            step_results.push_back(pend);
        end
    endfunction

    function automatic void add_row(input t_kind kind, input int srv, input int first,
                                    input int stop, input int cnt, input bit typed,
                                    input int slot, input bit found);
        t_stim_row row;
        row.req.kind          = kind;
        row.req.server_id     = SERVER_W'(srv);
        row.req.range_start   = START_W'(first);
        row.req.range_end     = END_W'(stop);
        row.req.release_count = COUNT_W'(cnt);
        row.typed             = typed;
        row.want.slot_index   = SLOT_W'(slot);
        row.want.found        = found;
        row.want.last         = 1'b1;
        dir_rows.push_back(row);
    endfunction

    // Offer one request item, with an optional gap first, and log its results on acceptance
    task automatic offer_request(input t_req r, input bit typed, input t_result want);
        int unsigned gap;
        if (idling && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 11);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.kind;
        s_tdata  <= {r.release_count, r.range_end, r.range_start, r.server_id};
        do @(posedge i_clk); while (o_s_tready !== 1'b1);
        predict_request(r);
        if (typed) begin
            freed_q.push_back(want);
        end else begin
            foreach (step_results[k]) freed_q.push_back(step_results[k]);
        end
    endtask

    // Accept results, compare with the oldest expectation, and stall in bursts
    initial begin
        t_result     exp_r;
        int unsigned stall_left;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (rst_n && o_m_tvalid === 1'b1 && m_tready) begin
                if (freed_q.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got slot %0d %s %0b %s %0b",
                             $time, o_m_tdata, "found", o_m_tuser, "last", o_m_tlast);
                    mismatch_count++;
                end else begin
                    exp_r = freed_q.pop_front();
                    if (o_m_tdata !== {2'b00, exp_r.slot_index}) begin
                        $display("%0t: slot_index mismatch, expected %0d, got %0d",
                                 $time, exp_r.slot_index, o_m_tdata);
                        mismatch_count++;
                    end
                    if (o_m_tuser !== exp_r.found) begin
                        $display("%0t: found mismatch, expected %0b, got %0b",
                                 $time, exp_r.found, o_m_tuser);
                        mismatch_count++;
                    end
                    if (o_m_tlast !== exp_r.last) begin
                        $display("%0t: last mismatch, expected %0b, got %0b",
                                 $time, exp_r.last, o_m_tlast);
                        mismatch_count++;
                    end
                end
            end
            if (!rst_n) begin
                m_tready <= 1'b0;
            end else if (stall_left != 0) begin
                stall_left--;
                if (stall_left == 0) m_tready <= 1'b1;
            end else if (idling && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(1, 11);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Bound the run
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("tb: failure");
        $finish;
    end

    initial begin
        t_req        r;
        t_result     none;
        int unsigned pick;
        int unsigned len;
        foreach (owned_words[w]) owned_words[w] = '0;
        none = '0;

        // Directed table: empty servers, extremes, empty ranges, clamps, word crossing
        add_row(KIND_RELEASE, 0,  0,     0,     1,   1, 0,     1'b0);
        add_row(KIND_RELEASE, 15, 0,     0,     127, 1, 0,     1'b0);
        add_row(KIND_SET,     0,  0,     1,     0,   0, 0,     1'b0);
        add_row(KIND_RELEASE, 0,  0,     0,     64,  1, 0,     1'b1);
        add_row(KIND_SET,     15, 16383, 16384, 0,   0, 0,     1'b0);
        add_row(KIND_RELEASE, 15, 0,     0,     1,   1, 16383, 1'b1);
        add_row(KIND_SET,     3,  100,   100,   0,   0, 0,     1'b0);
        add_row(KIND_RELEASE, 3,  0,     0,     5,   1, 0,     1'b0);
        add_row(KIND_SET,     3,  200,   100,   0,   0, 0,     1'b0);
        add_row(KIND_RELEASE, 3,  0,     0,     1,   1, 0,     1'b0);
        add_row(KIND_SET,     5,  0,     32767, 0,   0, 0,     1'b0);
        add_row(KIND_RELEASE, 5,  0,     0,     127, 0, 0,     1'b0);
        add_row(KIND_RELEASE, 5,  0,     0,     0,   1, 0,     1'b0);
        add_row(KIND_RELEASE, 5,  0,     0,     64,  0, 0,     1'b0);
        add_row(KIND_SET,     7,  60,    70,    0,   0, 0,     1'b0);
        add_row(KIND_RELEASE, 7,  0,     0,     20,  0, 0,     1'b0);
        add_row(KIND_SET,     9,  16380, 20000, 0,   0, 0,     1'b0);
        add_row(KIND_RELEASE, 9,  0,     0,     3,   0, 0,     1'b0);
        add_row(KIND_SET,     10, 16383, 0,     0,   0, 0,     1'b0);
        add_row(KIND_SET,     10, 63,    129,   0,   0, 0,     1'b0);
        add_row(KIND_RELEASE, 10, 0,     0,     65,  0, 0,     1'b0);
        add_row(KIND_RELEASE, 10, 0,     0,     2,   0, 0,     1'b0);

        // Hold reset, then release it at a clock edge
        repeat (9) @(posedge i_clk);
        rst_n <= 1'b1;

        foreach (dir_rows[i]) offer_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);

        // Random part: mostly short ranges low in the table and modest releases
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idling = (i < RANDOM_ITEMS - CALM_ITEMS) && ((i / 40) % 3 != 2);
            pick = $urandom_range(0, 99);
            r.server_id     = SERVER_W'($urandom);
            r.range_start   = START_W'($urandom);
            r.range_end     = END_W'($urandom);
            r.release_count = COUNT_W'($urandom);
            if (pick < 45) begin
                r.kind        = KIND_SET;
                len           = $urandom_range(0, 80);
                r.range_start = START_W'($urandom_range(0, 1023));
                r.range_end   = END_W'(r.range_start + len);
            end else if (pick < 82) begin
                r.kind          = KIND_RELEASE;
                r.release_count = COUNT_W'($urandom_range(0, 66));
            end else if (pick < 92) begin
                r.kind = KIND_RELEASE;
            end else begin
                r.kind = KIND_SET;
            end
            offer_request(r, 1'b0, none);
        end
        s_tvalid <= 1'b0;

        // Drain, then allow the last scan to finish
        while (freed_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);

        if (mismatch_count == 0 && freed_q.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ files.f @@
hw/rtl/sob_pkg.sv
hw/rtl/sob_ram.sv
hw/rtl/sob_out.sv
hw/rtl/sob_engine.sv
hw/rtl/slot_ownership_bitmap.sv
tb/tb.sv
